[sv/lrs_pkg.sv]
// shared types, constants and table functions of the logistic regression scorer
`timescale 1ns / 1ps
package lrs_pkg;

    // default sizes of the scorer
    localparam int NUM_FACTORS_DEF      = 8;
    localparam int MAX_LEVELS_DEF       = 5;
    localparam int SIGMOID_SEGMENTS_DEF = 32;

    // field and datapath widths
    localparam int FEAT_W  = 16;
    localparam int COEFF_W = 16;
    localparam int SCORE_W = 32;
    localparam int PROB_W  = 16;
    localparam int LEVEL_W = 3;
    localparam int ACC_W   = 38;
    localparam int DIFF_W  = 34;
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // logistic table covers [-8,8) in Q.16
    localparam logic signed [DIFF_W-1:0] HALF_RANGE = 34'sd524288;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_BIAS       = 3'd0;
    localparam logic [2:0] REG_NUM_LEVELS = 3'd1;
    localparam logic [2:0] REG_MODE       = 3'd2;
    localparam logic [2:0] REG_COEFF_LO   = 3'd3;
    localparam logic [2:0] REG_COEFF_HI   = 3'd4;
    localparam logic [2:0] REG_CUTOFF     = 3'd5;

    // outcome modes
    localparam logic [1:0] MODE_SIGN    = 2'd0;
    localparam logic [1:0] MODE_BINARY  = 2'd1;
    localparam logic [1:0] MODE_ORDINAL = 2'd2;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_0;
        logic signed [FEAT_W-1:0] feature_1;
        logic signed [FEAT_W-1:0] feature_2;
        logic signed [FEAT_W-1:0] feature_3;
        logic signed [FEAT_W-1:0] feature_4;
        logic signed [FEAT_W-1:0] feature_5;
        logic signed [FEAT_W-1:0] feature_6;
        logic signed [FEAT_W-1:0] feature_7;
        logic [PROB_W-1:0]        random_draw;
    } t_in;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [PROB_W-1:0]         probability;
        logic [LEVEL_W-1:0]        outcome;
    } t_out;

    // what travels down the ordinal level chain
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [PROB_W-1:0]         prob;
        logic [PROB_W-1:0]         draw;
        logic                      found;
        logic [LEVEL_W-1:0]        level;
    } t_carry;

    // feature of a given index
    function automatic logic signed [FEAT_W-1:0] lrs_feature(input t_in d, input int idx);
        logic signed [FEAT_W-1:0] f;
        unique case (idx)
            0: f = d.feature_0;
            1: f = d.feature_1;
            2: f = d.feature_2;
            3: f = d.feature_3;
            4: f = d.feature_4;
            5: f = d.feature_5;
            6: f = d.feature_6;
            default: f = d.feature_7;
        endcase
        return f;
    endfunction

    // restoring divide, used only for elaboration-time table values
    function automatic logic [63:0] lrs_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // logistic breakpoint k of a table with 2**seg_log2 segments, Q0.16
    function automatic logic [PROB_W-1:0] lrs_logistic(input int k, input int seg_log2);
        logic [63:0]        pos;
        logic signed [63:0] x;
        logic [63:0]        a;
        logic [63:0]        y;
        logic [63:0]        term;
        logic [63:0]        ey;
        logic [63:0]        r;
        logic [63:0]        den;
        logic [63:0]        q;
        pos = 64'(k) << (20 - seg_log2);
        x   = signed'(pos) - 64'sd524288;
        a   = (x < 0) ? 64'(-x) : 64'(x);
        y   = a << 10;
        term = 64'd1 << 30;
        ey   = 64'd1 << 30;
        for (int i = 1; i <= 15; i++) begin
            term = lrs_udiv((term * y) >> 30, 64'(i));
            ey   = ey + term;
        end
        r = lrs_udiv(64'd1 << 60, ey);
        for (int i = 0; i < 4; i++) begin
            r = (r * r) >> 30;
        end
        den = (64'd1 << 30) + r;
        if (x >= 0) begin
            q = lrs_udiv((64'd1 << 46) + (den >> 1), den);
        end else begin
            q = lrs_udiv((r << 16) + (den >> 1), den);
        end
        return (q > 64'd65535) ? 16'hFFFF : q[PROB_W-1:0];
    endfunction

endpackage

[sv/lrs_sigmoid.sv]
// two-stage piecewise-linear logistic lookup
`timescale 1ns / 1ps
module lrs_sigmoid #(
    parameter int SEGMENTS = lrs_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lrs_pkg::DIFF_W-1:0]   i_v,
    output logic [lrs_pkg::PROB_W-1:0]          o_prob
);
    // segment count is a power of two, so segments are 2**SH wide in Q.16
    localparam int SEG_LOG2 = $clog2(SEGMENTS);
    localparam int SH       = 20 - SEG_LOG2;

    logic [lrs_pkg::PROB_W-1:0] w_lut [0:SEGMENTS];

    // constant breakpoint table
    for (genvar k = 0; k <= SEGMENTS; k++) begin : g_lut
        localparam logic [lrs_pkg::PROB_W-1:0] LUT_K = lrs_pkg::lrs_logistic(k, SEG_LOG2);
        assign w_lut[k] = LUT_K;
    end

    logic signed [lrs_pkg::DIFF_W-1:0] w_u;
    logic [SEG_LOG2:0]                 w_j;
    logic                              w_sat_lo;
    logic                              w_sat_hi;
    logic [lrs_pkg::PROB_W-1:0]        n_base;
    logic [lrs_pkg::PROB_W-1:0]        n_diff;
    logic [SH-1:0]                     n_off;
    logic [lrs_pkg::PROB_W-1:0]        r_base;
    logic [lrs_pkg::PROB_W-1:0]        r_diff;
    logic [SH-1:0]                     r_off;
    logic [lrs_pkg::PROB_W+SH-1:0]     w_prod;
    logic [lrs_pkg::PROB_W-1:0]        r_prob;

    // segment select and table read
    always_comb begin
        w_u      = i_v + lrs_pkg::HALF_RANGE;
        w_j      = {1'b0, w_u[19:SH]};
        w_sat_lo = (i_v <= -lrs_pkg::HALF_RANGE);
        w_sat_hi = (i_v >= lrs_pkg::HALF_RANGE);
        n_off    = w_u[SH-1:0];
        if (w_sat_lo) begin
            n_base = w_lut[0];
            n_diff = '0;
        end else if (w_sat_hi) begin
            n_base = w_lut[SEGMENTS];
            n_diff = '0;
        end else begin
            n_base = w_lut[w_j];
            n_diff = w_lut[w_j + 1'b1] - w_lut[w_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= n_base;
            r_diff <= n_diff;
            r_off  <= n_off;
        end
    end

    // interpolation
    assign w_prod = (lrs_pkg::PROB_W + SH)'(r_diff) * (lrs_pkg::PROB_W + SH)'(r_off);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prob <= r_base + w_prod[lrs_pkg::PROB_W+SH-1:SH];
        end
    end

    assign o_prob = r_prob;

endmodule

[sv/lrs_mac_cell.sv]
// one multiply-accumulate cell of the dot product chain
`timescale 1ns / 1ps
module lrs_mac_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  lrs_pkg::t_in                       i_item,
    input  logic signed [lrs_pkg::ACC_W-1:0]   i_acc,
    input  logic signed [lrs_pkg::COEFF_W-1:0] i_coeff,
    input  logic signed [lrs_pkg::FEAT_W-1:0]  i_feat,
    output logic                               o_valid,
    output lrs_pkg::t_in                       o_item,
    output logic signed [lrs_pkg::ACC_W-1:0]   o_acc
);
    logic signed [31:0]                w_prod;
    logic signed [lrs_pkg::ACC_W-1:0]  n_acc;
    logic                              r_valid;
    lrs_pkg::t_in                      r_item;
    logic signed [lrs_pkg::ACC_W-1:0]  r_acc;

    // product is exact Q.20
    assign w_prod = i_coeff * i_feat;
    assign n_acc  = i_acc + lrs_pkg::ACC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= i_item;
            r_acc  <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_acc   = r_acc;

endmodule

[sv/lrs_level_cell.sv]
// one ordinal level cell: logistic of cutoff minus score against the draw
`timescale 1ns / 1ps
module lrs_level_cell #(
    parameter int SEGMENTS = lrs_pkg::SIGMOID_SEGMENTS_DEF,
    parameter int IDX      = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  lrs_pkg::t_carry                     i_carry,
    input  logic signed [lrs_pkg::FEAT_W-1:0]   i_cut,
    input  logic [lrs_pkg::LEVEL_W-1:0]         i_levels,
    output logic                                o_valid,
    output lrs_pkg::t_carry                     o_carry
);
    logic signed [lrs_pkg::DIFF_W-1:0] w_v;
    logic [lrs_pkg::PROB_W-1:0]        w_sig;
    logic                              r_v1;
    logic                              r_v2;
    lrs_pkg::t_carry                   r_c1;
    lrs_pkg::t_carry                   r_c2;
    logic                              w_active;

    // exact difference cutoff*256 - score
    assign w_v = (lrs_pkg::DIFF_W'(i_cut) <<< 8) - lrs_pkg::DIFF_W'(i_carry.score);

    lrs_sigmoid #(
        .SEGMENTS (SEGMENTS)
    ) u_sig (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_v    (w_v),
        .o_prob (w_sig)
    );

    // carry delayed alongside the lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_carry;
            r_c2 <= r_c1;
        end
    end

    // first level whose cumulative probability exceeds the draw
    assign w_active = (lrs_pkg::LEVEL_W'(IDX + 1) < i_levels);

    always_comb begin
        o_carry = r_c2;
        if (!r_c2.found && w_active && (r_c2.draw < w_sig)) begin
            o_carry.found = 1'b1;
            o_carry.level = lrs_pkg::LEVEL_W'(IDX);
        end
    end

    assign o_valid = r_v2;

endmodule

[sv/logistic_regression_scorer_unit.sv]
// top level of the logistic regression scorer: registers, mac chain, level chain
//
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_data  (t_in)
// output   out        o_valid / i_stall  o_data  (t_out)
// config   in         psel / penable     paddr, pwdata, prdata
//
// one beat accepted per cycle while o_stall is low. in order, a beat passes the mac
// cells, the score saturation register, the probability lookup registers, the
// ordinal level cells and the output register.
// the whole pipeline advances together; it holds only while the output beat is
// stalled, and then o_stall is raised.
// synchronous active-low reset clears the valid bits and loads register defaults.
`timescale 1ns / 1ps
module logistic_regression_scorer_unit #(
    parameter int NUM_FACTORS      = lrs_pkg::NUM_FACTORS_DEF,
    parameter int MAX_LEVELS       = lrs_pkg::MAX_LEVELS_DEF,
    parameter int SIGMOID_SEGMENTS = lrs_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  lrs_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output lrs_pkg::t_out                 o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrs_pkg::PADDR_W-1:0]   paddr,
    input  logic [lrs_pkg::PDATA_W-1:0]   pwdata,
    output logic [lrs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int NL = MAX_LEVELS - 1;

    logic signed [lrs_pkg::SCORE_W-1:0] r_bias;
    logic [lrs_pkg::LEVEL_W-1:0]        r_levels;
    logic [1:0]                         r_mode;
    logic [63:0]                        r_coeff_lo;
    logic [63:0]                        r_coeff_hi;
    logic [63:0]                        r_cutoff;
    logic                               w_wr;
    logic [2:0]                         w_idx;
    logic                               w_en;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias     <= '0;
            r_levels   <= 3'd2;
            r_mode     <= lrs_pkg::MODE_SIGN;
            r_coeff_lo <= '0;
            r_coeff_hi <= '0;
            r_cutoff   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                lrs_pkg::REG_BIAS:       r_bias     <= pwdata[31:0];
                lrs_pkg::REG_NUM_LEVELS: r_levels   <= pwdata[2:0];
                lrs_pkg::REG_MODE:       r_mode     <= pwdata[1:0];
                lrs_pkg::REG_COEFF_LO:   r_coeff_lo <= pwdata;
                lrs_pkg::REG_COEFF_HI:   r_coeff_hi <= pwdata;
                lrs_pkg::REG_CUTOFF:     r_cutoff   <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_idx)
            lrs_pkg::REG_BIAS:       prdata = {{32{r_bias[31]}}, r_bias};
            lrs_pkg::REG_NUM_LEVELS: prdata = 64'(r_levels);
            lrs_pkg::REG_MODE:       prdata = 64'(r_mode);
            lrs_pkg::REG_COEFF_LO:   prdata = r_coeff_lo;
            lrs_pkg::REG_COEFF_HI:   prdata = r_coeff_hi;
            lrs_pkg::REG_CUTOFF:     prdata = r_cutoff;
            default:                 prdata = '0;
        endcase
    end

    // pipeline advance
    logic r_out_v;
    assign w_en    = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    // mac chain
    logic                              w_mv   [0:NUM_FACTORS];
    lrs_pkg::t_in                      w_mi   [0:NUM_FACTORS];
    logic signed [lrs_pkg::ACC_W-1:0]  w_macc [0:NUM_FACTORS];

    assign w_mv[0]   = i_valid;
    assign w_mi[0]   = i_data;
    assign w_macc[0] = lrs_pkg::ACC_W'(r_bias) <<< 4;

    for (genvar k = 0; k < NUM_FACTORS; k++) begin : g_mac
        logic signed [lrs_pkg::COEFF_W-1:0] w_coeff;
        if (k < 4) begin : g_lo
            assign w_coeff = r_coeff_lo[16*k +: 16];
        end else begin : g_hi
            assign w_coeff = r_coeff_hi[16*(k-4) +: 16];
        end
        lrs_mac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_mv[k]),
            .i_item  (w_mi[k]),
            .i_acc   (w_macc[k]),
            .i_coeff (w_coeff),
            .i_feat  (lrs_pkg::lrs_feature(w_mi[k], k)),
            .o_valid (w_mv[k+1]),
            .o_item  (w_mi[k+1]),
            .o_acc   (w_macc[k+1])
        );
    end

    // score: floor divide by 16 and saturate
    logic signed [lrs_pkg::ACC_W-1:0]   w_shift;
    logic signed [lrs_pkg::SCORE_W-1:0] n_score;
    logic                               r_sc_v;
    logic signed [lrs_pkg::SCORE_W-1:0] r_score;
    logic [lrs_pkg::PROB_W-1:0]         r_sc_draw;

    always_comb begin
        w_shift = w_macc[NUM_FACTORS] >>> 4;
        if (w_shift > lrs_pkg::ACC_W'(64'sd2147483647)) begin
            n_score = 32'sh7FFFFFFF;
        end else if (w_shift < -lrs_pkg::ACC_W'(64'sd2147483648)) begin
            n_score = 32'sh80000000;
        end else begin
            n_score = w_shift[lrs_pkg::SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v <= 1'b0;
        end else if (w_en) begin
            r_sc_v <= w_mv[NUM_FACTORS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_score   <= n_score;
            r_sc_draw <= w_mi[NUM_FACTORS].random_draw;
        end
    end

    // probability lookup with matching delay
    logic [lrs_pkg::PROB_W-1:0]         w_prob;
    logic                               r_pv1;
    logic                               r_pv2;
    logic signed [lrs_pkg::SCORE_W-1:0] r_ps1;
    logic signed [lrs_pkg::SCORE_W-1:0] r_ps2;
    logic [lrs_pkg::PROB_W-1:0]         r_pd1;
    logic [lrs_pkg::PROB_W-1:0]         r_pd2;

    lrs_sigmoid #(
        .SEGMENTS (SIGMOID_SEGMENTS)
    ) u_prob (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (lrs_pkg::DIFF_W'(r_score)),
        .o_prob (w_prob)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv1 <= 1'b0;
            r_pv2 <= 1'b0;
        end else if (w_en) begin
            r_pv1 <= r_sc_v;
            r_pv2 <= r_pv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ps1 <= r_score;
            r_ps2 <= r_ps1;
            r_pd1 <= r_sc_draw;
            r_pd2 <= r_pd1;
        end
    end

    // effective level count
    logic [lrs_pkg::LEVEL_W-1:0] w_levels;
    always_comb begin
        if (r_levels < 3'd2) begin
            w_levels = 3'd2;
        end else if (r_levels > lrs_pkg::LEVEL_W'(MAX_LEVELS)) begin
            w_levels = lrs_pkg::LEVEL_W'(MAX_LEVELS);
        end else begin
            w_levels = r_levels;
        end
    end

    // ordinal level chain
    logic            w_lv [0:NL];
    lrs_pkg::t_carry w_lc [0:NL];

    assign w_lv[0]       = r_pv2;
    assign w_lc[0].score = r_ps2;
    assign w_lc[0].prob  = w_prob;
    assign w_lc[0].draw  = r_pd2;
    assign w_lc[0].found = 1'b0;
    assign w_lc[0].level = '0;

    for (genvar i = 0; i < NL; i++) begin : g_lvl
        lrs_level_cell #(
            .SEGMENTS (SIGMOID_SEGMENTS),
            .IDX      (i)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_lv[i]),
            .i_carry  (w_lc[i]),
            .i_cut    (r_cutoff[16*i +: 16]),
            .i_levels (w_levels),
            .o_valid  (w_lv[i+1]),
            .o_carry  (w_lc[i+1])
        );
    end

    // outcome select and output register
    lrs_pkg::t_carry             w_fin;
    logic [lrs_pkg::LEVEL_W-1:0] n_outcome;
    lrs_pkg::t_out               r_out;

    assign w_fin = w_lc[NL];

    always_comb begin
        unique case (r_mode)
            lrs_pkg::MODE_SIGN:    n_outcome = w_fin.score[31] ? 3'd0 : 3'd1;
            lrs_pkg::MODE_BINARY:  n_outcome = (w_fin.draw <= w_fin.prob) ? 3'd1 : 3'd0;
            lrs_pkg::MODE_ORDINAL: n_outcome = w_fin.found ? w_fin.level : w_levels - 3'd1;
            default:               n_outcome = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_lv[NL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.score       <= w_fin.score;
            r_out.probability <= w_fin.prob;
            r_out.outcome     <= n_outcome;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output beat");

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.outcome <= lrs_pkg::LEVEL_W'(MAX_LEVELS - 1)))
        else $error("outcome beyond the last level");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

[dv/logistic_regression_scorer_unit_tb.sv]
// testbench of the logistic regression scorer: directed and random beats against a predictor
`timescale 1ns / 1ps
module logistic_regression_scorer_unit_tb;

    localparam int  SEGMENTS    = 32;
    localparam int  LEVELS_MAX  = 5;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 40;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    lrs_pkg::t_in                 i_data = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    lrs_pkg::t_out                o_data;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [lrs_pkg::PADDR_W-1:0]  paddr = '0;
    logic [lrs_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [lrs_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    logistic_regression_scorer_unit dut (.*);

    // shadow of the block's registers
    logic signed [31:0]  sh_bias;
    logic [2:0]          sh_levels;
    logic [1:0]          sh_mode;
    logic [63:0]         sh_coeff_lo;
    logic [63:0]         sh_coeff_hi;
    logic [63:0]         sh_cutoff;

    bit [15:0]           sig_val[SEGMENTS+1];
    lrs_pkg::t_out       expected_scores[$];
    int                  errors = 0;
    int                  cycles = 0;
    bit                  quiet = 1'b0;
    int                  hold_left = 0;
    int                  stall_burst = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // exact logistic of a breakpoint, Q0.16
    function automatic bit [15:0] logistic_point(input int k);
        longint    x;
        bit [63:0] a, y, term, ey, r, den, q;
        x = (longint'(k) <<< 15) - 64'sd524288;
        a = (x < 0) ? -x : x;
        y = a << 10;
        term = 64'd1 << 30;
        ey = 64'd1 << 30;
        for (int i = 1; i <= 15; i++) begin
            term = ((term * y) >> 30) / 64'(i);
            ey = ey + term;
        end
        r = (64'd1 << 60) / ey;
        for (int i = 0; i < 4; i++) r = (r * r) >> 30;
        den = (64'd1 << 30) + r;
        if (x >= 0) q = ((64'd1 << 46) + den / 2) / den;
        else q = ((r << 16) + den / 2) / den;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // piecewise-linear logistic of a Q.16 value
    function automatic bit [15:0] pwl_sigmoid(input longint v);
        bit [63:0] u, j, d, base;
        if (v <= -64'sd524288) return sig_val[0];
        if (v >= 64'sd524288) return sig_val[SEGMENTS];
        u = v + 64'sd524288;
        j = (u * SEGMENTS) >> 20;
        if (j >= SEGMENTS) j = SEGMENTS - 1;
        d = sig_val[j+1] - sig_val[j];
        base = j << 15;
        return 16'(sig_val[j] + (d * (u - base)) / 64'd32768);
    endfunction

    function automatic longint half_of(input logic [63:0] w, input int slot);
        return longint'($signed(w[16*slot +: 16]));
    endfunction

    // expected result of one observation under the current registers
    function automatic lrs_pkg::t_out score_observation(input lrs_pkg::t_in d);
        longint acc, s, cut;
        logic signed [15:0] f[8];
        int lv;
        lrs_pkg::t_out r;
        f = '{d.feature_0, d.feature_1, d.feature_2, d.feature_3,
              d.feature_4, d.feature_5, d.feature_6, d.feature_7};
        acc = longint'(sh_bias) * 16;
        for (int i = 0; i < 8; i++)
            acc += half_of(i < 4 ? sh_coeff_lo : sh_coeff_hi, i % 4) * longint'(f[i]);
        s = acc >>> 4;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        r.score = s[31:0];
        r.probability = pwl_sigmoid(s);
        r.outcome = '0;
        case (sh_mode)
            lrs_pkg::MODE_SIGN:   r.outcome = (s >= 0) ? 3'd1 : 3'd0;
            lrs_pkg::MODE_BINARY: r.outcome = (d.random_draw <= r.probability) ? 3'd1 : 3'd0;
            lrs_pkg::MODE_ORDINAL: begin
                lv = (sh_levels < 2) ? 2 : (sh_levels > LEVELS_MAX) ? LEVELS_MAX : sh_levels;
                r.outcome = 3'(lv - 1);
                for (int i = 0; i < lv - 1; i++) begin
                    cut = half_of(sh_cutoff, i) * 256;
                    if (d.random_draw < pwl_sigmoid(cut - s)) begin
                        r.outcome = 3'(i);
                        break;
                    end
                end
            end
            default: r.outcome = '0;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        lrs_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_scores.size() == 0) begin
                $error("unexpected result beat score=%0d", o_data.score);
                errors++;
            end else begin
                want = expected_scores.pop_front();
                if (o_data.score !== want.score) begin
                    $error("score expected %0d actual %0d", want.score, o_data.score);
                    errors++;
                end
                if (o_data.probability !== want.probability) begin
                    $error("probability expected %0d actual %0d",
                           want.probability, o_data.probability);
                    errors++;
                end
                if (o_data.outcome !== want.outcome) begin
                    $error("outcome expected %0d actual %0d", want.outcome, o_data.outcome);
                    errors++;
                end
            end
        end
    end

    // output stall: long hold on request, else random bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (stall_burst > 0) begin
            i_stall <= 1'b1;
            stall_burst--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_burst = $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // register write over the config port, shadow updated alongside
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lrs_pkg::REG_BIAS:       sh_bias = value[31:0];
            lrs_pkg::REG_NUM_LEVELS: sh_levels = value[2:0];
            lrs_pkg::REG_MODE:       sh_mode = value[1:0];
            lrs_pkg::REG_COEFF_LO:   sh_coeff_lo = value;
            lrs_pkg::REG_COEFF_HI:   sh_coeff_hi = value;
            lrs_pkg::REG_CUTOFF:     sh_cutoff = value;
            default: ;
        endcase
    endtask

    // stop offering beats and wait until every result is back
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // send one observation beat, then an optional random gap
    task automatic send_observation(input lrs_pkg::t_in d, input bit gaps);
        i_valid <= 1'b1;
        i_data <= d;
        do @(posedge i_clk); while (o_stall);
        expected_scores.push_back(score_observation(d));
        if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    function automatic lrs_pkg::t_in rand_observation(input bit narrow);
        lrs_pkg::t_in d;
        d = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        if (narrow) begin
            d.feature_0 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_1 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_2 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_3 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_4 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_5 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_6 = 16'($signed($urandom_range(0, 1023)) - 512);
            d.feature_7 = 16'($signed($urandom_range(0, 1023)) - 512);
        end
        return d;
    endfunction

    // four halfwords, either full range or kept within +-lim
    function automatic logic [63:0] rand_halves(input bit narrow, input int lim);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (narrow)
            for (int i = 0; i < 4; i++)
                w[16*i +: 16] = 16'($signed($urandom_range(0, 2*lim)) - lim);
        return w;
    endfunction

    task automatic test_sign_extremes();
        lrs_pkg::t_in d;
        write_reg(lrs_pkg::REG_MODE, 64'(lrs_pkg::MODE_SIGN));
        write_reg(lrs_pkg::REG_COEFF_LO, {4{16'h7FFF}});
        write_reg(lrs_pkg::REG_COEFF_HI, {4{16'h8000}});
        write_reg(lrs_pkg::REG_BIAS, 64'h7FFF_FFFF);
        d = {{4{16'h7FFF}}, {4{16'h8000}}, 16'hFFFF};
        send_observation(d, 1'b0);
        d = {{4{16'h8000}}, {4{16'h7FFF}}, 16'h0000};
        send_observation(d, 1'b0);
        send_observation('0, 1'b0);
        wait_idle();
        write_reg(lrs_pkg::REG_BIAS, 64'hFFFF_FFFF_8000_0000);
        send_observation(d, 1'b0);
        send_observation({{8{16'h8000}}, 16'h8000}, 1'b0);
        send_observation('0, 1'b0);
        wait_idle();
        // score around the table edges
        write_reg(lrs_pkg::REG_COEFF_LO, 64'h0000_0000_0000_1000);
        write_reg(lrs_pkg::REG_COEFF_HI, 64'h0);
        write_reg(lrs_pkg::REG_BIAS, 64'h0);
        send_observation({16'h0800, {7{16'h0}}, 16'h1234}, 1'b0);
        send_observation({16'hF800, {7{16'h0}}, 16'h1234}, 1'b0);
        send_observation({16'h07FF, {7{16'h0}}, 16'h1234}, 1'b0);
        send_observation({16'hF801, {7{16'h0}}, 16'h1234}, 1'b0);
        send_observation({16'hFFFF, {7{16'h0}}, 16'h1234}, 1'b0);
        wait_idle();
    endtask

    task automatic test_binary_draw();
        write_reg(lrs_pkg::REG_MODE, 64'(lrs_pkg::MODE_BINARY));
        send_observation({16'h0100, {7{16'h0}}, 16'h0000}, 1'b0);
        send_observation({16'h0100, {7{16'h0}}, 16'hFFFF}, 1'b0);
        send_observation({16'h0000, {7{16'h0}}, 16'h8000}, 1'b0);
        send_observation({16'h0000, {7{16'h0}}, 16'h7FFF}, 1'b0);
        wait_idle();
    endtask

    task automatic test_ordinal_levels();
        write_reg(lrs_pkg::REG_MODE, 64'(lrs_pkg::MODE_ORDINAL));
        write_reg(lrs_pkg::REG_CUTOFF, {16'h0200, 16'h0100, 16'h0000, 16'hFF00});
        for (int n = 0; n < 8; n++) begin
            write_reg(lrs_pkg::REG_NUM_LEVELS, 64'(n));
            send_observation({16'h0000, {7{16'h0}}, 16'hFFFF}, 1'b0);
            send_observation({16'h0000, {7{16'h0}}, 16'h0000}, 1'b0);
            wait_idle();
        end
    endtask

    task automatic test_unused_mode_and_index();
        write_reg(lrs_pkg::REG_MODE, 64'd3);
        write_reg(REG_SPARE_A, {64{1'b1}});
        write_reg(REG_SPARE_B, {64{1'b1}});
        send_observation({16'h0100, {7{16'h0}}, 16'h0000}, 1'b0);
        send_observation({16'hFF00, {7{16'h0}}, 16'h0000}, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        bit narrow;
        for (int p = 0; p < phases; p++) begin
            narrow = ($urandom_range(0, 3) != 0);
            write_reg(lrs_pkg::REG_MODE, 64'($urandom_range(0, 3)));
            write_reg(lrs_pkg::REG_NUM_LEVELS, 64'($urandom_range(0, 7)));
            write_reg(lrs_pkg::REG_BIAS,
                      narrow ? 64'($signed($urandom_range(0, 1 << 20)) - (1 << 19))
                             : 64'($urandom));
            write_reg(lrs_pkg::REG_COEFF_LO, rand_halves(narrow, 1024));
            write_reg(lrs_pkg::REG_COEFF_HI, rand_halves(narrow, 1024));
            write_reg(lrs_pkg::REG_CUTOFF, rand_halves($urandom_range(0, 4) != 0, 2304));
            for (int i = 0; i < per_phase; i++)
                send_observation(rand_observation(narrow && $urandom_range(0, 4) != 0), 1'b1);
            wait_idle();
        end
    endtask

    // receiver holds off long while beats keep coming, so the pipe fills
    task automatic test_backpressure();
        write_reg(lrs_pkg::REG_MODE, 64'(lrs_pkg::MODE_ORDINAL));
        write_reg(lrs_pkg::REG_NUM_LEVELS, 64'd5);
        hold_left = 150;
        for (int i = 0; i < 60; i++) send_observation(rand_observation(1'b1), 1'b0);
        wait_idle();
    endtask

    initial begin
        for (int k = 0; k <= SEGMENTS; k++) sig_val[k] = logistic_point(k);
        sh_bias = '0;
        sh_levels = 3'd2;
        sh_mode = lrs_pkg::MODE_SIGN;
        sh_coeff_lo = '0;
        sh_coeff_hi = '0;
        sh_cutoff = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sign_extremes();
        test_binary_draw();
        test_ordinal_levels();
        test_unused_mode_and_index();
        test_random_phases(10, 60);
        test_backpressure();
        quiet = 1'b1;
        test_random_phases(1, 60);

        i_valid <= 1'b0;
        wait_idle();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[logistic_regression_scorer_unit.f]
sv/lrs_pkg.sv
sv/lrs_sigmoid.sv
sv/lrs_mac_cell.sv
sv/lrs_level_cell.sv
sv/logistic_regression_scorer_unit.sv
dv/logistic_regression_scorer_unit_tb.sv
